FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the RTL checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, always on
`define ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ted_pkg.sv
// ----------------------------------------------------------------------------
// TSP edge distance package
// Field widths, metric codes and the tag that rides along the pipeline.
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int FIELD_W           = 24;
  localparam int DIST_W            = 22;
  localparam int METRIC_W          = 4;
  localparam int COORD_WIDTH_DEF   = 24;
  localparam int FRACTION_BITS_DEF = 4;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [METRIC_W-1:0]       metric_t;

  localparam metric_t METRIC_ATT     = 4'd0;
  localparam metric_t METRIC_CEIL2D  = 4'd1;
  localparam metric_t METRIC_CEIL3D  = 4'd2;
  localparam metric_t METRIC_EUC2D   = 4'd3;
  localparam metric_t METRIC_EUC3D   = 4'd4;
  localparam metric_t METRIC_FLOOR2D = 4'd5;
  localparam metric_t METRIC_FLOOR3D = 4'd6;
  localparam metric_t METRIC_MAN2D   = 4'd7;
  localparam metric_t METRIC_MAN3D   = 4'd8;
  localparam metric_t METRIC_MAX2D   = 4'd9;
  localparam metric_t METRIC_MAX3D   = 4'd10;
  localparam metric_t METRIC_RESET   = METRIC_EUC2D;

  // metric plus the result of the metrics that need no square root
  typedef struct packed {
    metric_t metric;
    dist_t   alt;
  } tag_t;

  function automatic logic is_3d(metric_t m);
    logic r;
    unique case (m) inside
      METRIC_CEIL3D, METRIC_EUC3D, METRIC_FLOOR3D, METRIC_MAN3D, METRIC_MAX3D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/ted_point_if.sv
// ----------------------------------------------------------------------------
// Point pair channel
// Valid/ready channel carrying two points, three coordinates each.
// ----------------------------------------------------------------------------
interface ted_point_if;
  logic            valid;
  logic            ready;
  ted_pkg::coord_t ax;
  ted_pkg::coord_t ay;
  ted_pkg::coord_t az;
  ted_pkg::coord_t bx;
  ted_pkg::coord_t by;
  ted_pkg::coord_t bz;

  modport source (output valid, output ax, output ay, output az,
                  output bx, output by, output bz, input ready);
  modport sink   (input valid, input ax, input ay, input az,
                  input bx, input by, input bz, output ready);
endinterface

FILE: rtl/ted_dist_if.sv
// ----------------------------------------------------------------------------
// Distance channel
// Valid/ready channel carrying one integer edge weight.
// ----------------------------------------------------------------------------
interface ted_dist_if;
  logic           valid;
  logic           ready;
  ted_pkg::dist_t distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

FILE: rtl/tsp_edge_distance_unit.sv
// ----------------------------------------------------------------------------
// TSP edge distance unit
// Pipeline: 4 front stages, one square root cell per root bit (COORD_WIDTH + 3),
// and 2 back stages incl. output reg.
// Throughput: one point pair per cycle; each stage holds only while full and
// blocked, so bubbles close up under output backpressure.
// Reset clears all stage valids and sets the metric register to EUC2D.
// ----------------------------------------------------------------------------
module tsp_edge_distance_unit #(
  parameter int COORD_WIDTH   = ted_pkg::COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = ted_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  ted_pkg::metric_t cfg_wdata,
  ted_point_if.sink        in_ch,
  ted_dist_if.source       out_ch
);

  localparam int V_W = 2 * COORD_WIDTH + 5;
  localparam int R_W = COORD_WIDTH + 3;

  ted_pkg::metric_t metric_r;

  logic           c_valid [R_W+1];
  logic           c_ready [R_W+1];
  logic [V_W-1:0] c_rem   [R_W+1];
  logic [R_W-1:0] c_root  [R_W+1];
  ted_pkg::tag_t  c_tag   [R_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= ted_pkg::METRIC_RESET;
    end else if (cfg_we) begin
      metric_r <= cfg_wdata;
    end
  end

  ted_prep #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .metric   (metric_r),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .ax       (in_ch.ax),
    .ay       (in_ch.ay),
    .az       (in_ch.az),
    .bx       (in_ch.bx),
    .by       (in_ch.by),
    .bz       (in_ch.bz),
    .dn_valid (c_valid[0]),
    .dn_ready (c_ready[0]),
    .dn_v     (c_rem[0]),
    .dn_tag   (c_tag[0])
  );

  assign c_root[0] = '0;

  for (genvar gi = 0; gi < R_W; gi++) begin : g_cell
    ted_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .BIT_POS     (R_W - 1 - gi)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (c_valid[gi]),
      .up_ready (c_ready[gi]),
      .up_rem   (c_rem[gi]),
      .up_root  (c_root[gi]),
      .up_tag   (c_tag[gi]),
      .dn_valid (c_valid[gi+1]),
      .dn_ready (c_ready[gi+1]),
      .dn_rem   (c_rem[gi+1]),
      .dn_root  (c_root[gi+1]),
      .dn_tag   (c_tag[gi+1])
    );
  end

  ted_post #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_valid    (c_valid[R_W]),
    .up_ready    (c_ready[R_W]),
    .up_rem      (c_rem[R_W]),
    .up_root     (c_root[R_W]),
    .up_tag      (c_tag[R_W]),
    .dn_valid    (out_ch.valid),
    .dn_ready    (out_ch.ready),
    .dn_distance (out_ch.distance)
  );

endmodule

FILE: rtl/ted_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// One restoring square root step: settles one root bit and hands the
// partial remainder, partial root and tag to the next cell.
// ----------------------------------------------------------------------------
module ted_cell #(
  parameter int  COORD_WIDTH = ted_pkg::COORD_WIDTH_DEF,
  parameter int  BIT_POS     = 0,
  localparam int V_W         = 2 * COORD_WIDTH + 5,
  localparam int R_W         = COORD_WIDTH + 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  logic [V_W-1:0] up_rem,
  input  logic [R_W-1:0] up_root,
  input  ted_pkg::tag_t up_tag,
  output logic          dn_valid,
  input  logic          dn_ready,
  output logic [V_W-1:0] dn_rem,
  output logic [R_W-1:0] dn_root,
  output ted_pkg::tag_t dn_tag
);

  localparam int T_W = V_W + 1;

  logic           valid_r;
  logic [V_W-1:0] rem_r, rem_nxt;
  logic [R_W-1:0] root_r, root_nxt;
  ted_pkg::tag_t  tag_r;
  logic [T_W-1:0] trial, rem_ext, diff;
  logic           fits;

  // trial = 2 * root * 2^k + 4^k, root holds only bits above k
  always_comb begin
    trial    = (T_W'(up_root) << (BIT_POS + 1)) | (T_W'(1) << (2 * BIT_POS));
    rem_ext  = T_W'(up_rem);
    diff     = rem_ext - trial;
    fits     = (rem_ext >= trial);
    rem_nxt  = fits ? diff[V_W-1:0] : up_rem;
    root_nxt = fits ? (up_root | (R_W'(1) << BIT_POS)) : up_root;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      tag_r  <= up_tag;
    end
  end

  assign dn_valid = valid_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_tag   = tag_r;

endmodule

FILE: rtl/ted_prep.sv
// ----------------------------------------------------------------------------
// Distance front end
// Absolute differences, squares, sum of squares and the scaled radicand;
// Manhattan and Chebyshev results are finished here and ride in the tag.
// ----------------------------------------------------------------------------
module ted_prep #(
  parameter int  COORD_WIDTH   = ted_pkg::COORD_WIDTH_DEF,
  parameter int  FRACTION_BITS = ted_pkg::FRACTION_BITS_DEF,
  localparam int V_W           = 2 * COORD_WIDTH + 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ted_pkg::metric_t metric,
  input  logic             in_valid,
  output logic             in_ready,
  input  ted_pkg::coord_t  ax,
  input  ted_pkg::coord_t  ay,
  input  ted_pkg::coord_t  az,
  input  ted_pkg::coord_t  bx,
  input  ted_pkg::coord_t  by,
  input  ted_pkg::coord_t  bz,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [V_W-1:0]   dn_v,
  output ted_pkg::tag_t    dn_tag
);

  localparam int CW   = COORD_WIDTH;
  localparam int SW   = 2 * CW;
  localparam int SUMW = 2 * CW + 2;
  localparam int AW   = CW + 2;
  localparam int RW1  = CW + 1;
  localparam int HALF = (1 << FRACTION_BITS) >> 1;

  function automatic logic [CW-1:0] abs_diff(ted_pkg::coord_t a, ted_pkg::coord_t b);
    logic signed [CW:0] d;
    d = $signed({a[CW-1], a[CW-1:0]}) - $signed({b[CW-1], b[CW-1:0]});
    return d[CW] ? CW'(-d) : CW'(d);
  endfunction

  logic             f1_valid_r, f2_valid_r, f3_valid_r, f4_valid_r;
  logic             f1_rdy, f2_rdy, f3_rdy, f4_rdy;
  ted_pkg::metric_t f1_metric_r, f2_metric_r, f3_metric_r;
  logic [CW-1:0]    f1_dx_r, f1_dy_r, f1_dz_r;
  logic [SW-1:0]    f2_sx_r, f2_sy_r, f2_sz_r;
  ted_pkg::dist_t   f2_alt_r, f3_alt_r, alt_nxt;
  logic [SUMW-1:0]  f3_s_r;
  logic [V_W-1:0]   f4_v_r, v_nxt;
  ted_pkg::tag_t    f4_tag_r;
  logic [AW-1:0]    man;
  logic [RW1-1:0]   rx, ry, rz, mx;

  assign f4_rdy   = !f4_valid_r || dn_ready;
  assign f3_rdy   = !f3_valid_r || f4_rdy;
  assign f2_rdy   = !f2_valid_r || f3_rdy;
  assign f1_rdy   = !f1_valid_r || f2_rdy;
  assign in_ready = f1_rdy;

  always_comb begin
    man = (AW'(f1_dx_r) + AW'(f1_dy_r) + AW'(f1_dz_r) + AW'(HALF)) >> FRACTION_BITS;
    rx  = (RW1'(f1_dx_r) + RW1'(HALF)) >> FRACTION_BITS;
    ry  = (RW1'(f1_dy_r) + RW1'(HALF)) >> FRACTION_BITS;
    rz  = (RW1'(f1_dz_r) + RW1'(HALF)) >> FRACTION_BITS;
    mx  = (ry > rx) ? ry : rx;
    mx  = (rz > mx) ? rz : mx;
    unique case (f1_metric_r) inside
      ted_pkg::METRIC_MAN2D, ted_pkg::METRIC_MAN3D: alt_nxt = ted_pkg::DIST_W'(man);
      ted_pkg::METRIC_MAX2D, ted_pkg::METRIC_MAX3D: alt_nxt = ted_pkg::DIST_W'(mx);
      default:                                      alt_nxt = '0;
    endcase
  end

  always_comb begin
    unique case (f3_metric_r) inside
      ted_pkg::METRIC_ATT: v_nxt = (V_W'(f3_s_r) << 3) + (V_W'(f3_s_r) << 1);
      ted_pkg::METRIC_EUC2D, ted_pkg::METRIC_EUC3D: v_nxt = V_W'(f3_s_r) << 2;
      default: v_nxt = V_W'(f3_s_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
      f4_valid_r <= 1'b0;
    end else begin
      if (f1_rdy) f1_valid_r <= in_valid;
      if (f2_rdy) f2_valid_r <= f1_valid_r;
      if (f3_rdy) f3_valid_r <= f2_valid_r;
      if (f4_rdy) f4_valid_r <= f3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy && in_valid) begin
      f1_metric_r <= metric;
      f1_dx_r     <= abs_diff(ax, bx);
      f1_dy_r     <= abs_diff(ay, by);
      f1_dz_r     <= ted_pkg::is_3d(metric) ? abs_diff(az, bz) : '0;
    end
    if (f2_rdy && f1_valid_r) begin
      f2_metric_r <= f1_metric_r;
      f2_sx_r     <= SW'(f1_dx_r) * SW'(f1_dx_r);
      f2_sy_r     <= SW'(f1_dy_r) * SW'(f1_dy_r);
      f2_sz_r     <= SW'(f1_dz_r) * SW'(f1_dz_r);
      f2_alt_r    <= alt_nxt;
    end
    if (f3_rdy && f2_valid_r) begin
      f3_metric_r <= f2_metric_r;
      f3_s_r      <= SUMW'(f2_sx_r) + SUMW'(f2_sy_r) + SUMW'(f2_sz_r);
      f3_alt_r    <= f2_alt_r;
    end
    if (f4_rdy && f3_valid_r) begin
      f4_v_r          <= v_nxt;
      f4_tag_r.metric <= f3_metric_r;
      f4_tag_r.alt    <= f3_alt_r;
    end
  end

  assign dn_valid = f4_valid_r;
  assign dn_v     = f4_v_r;
  assign dn_tag   = f4_tag_r;

endmodule

FILE: rtl/ted_post.sv
// ----------------------------------------------------------------------------
// Distance back end
// Turns the integer root and its exactness into the rounded weight of the
// selected metric; ATT divides by ten through a reciprocal multiply.
// ----------------------------------------------------------------------------
module ted_post #(
  parameter int  COORD_WIDTH   = ted_pkg::COORD_WIDTH_DEF,
  parameter int  FRACTION_BITS = ted_pkg::FRACTION_BITS_DEF,
  localparam int V_W           = 2 * COORD_WIDTH + 5,
  localparam int R_W           = COORD_WIDTH + 3
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  logic [V_W-1:0] up_rem,
  input  logic [R_W-1:0] up_root,
  input  ted_pkg::tag_t  up_tag,
  output logic           dn_valid,
  input  logic           dn_ready,
  output ted_pkg::dist_t dn_distance
);

  localparam int U_W = R_W - FRACTION_BITS;
  localparam int SH  = U_W + 4;
  localparam int M_W = U_W + 1;
  localparam int P_W = U_W + M_W;
  localparam logic [M_W-1:0] RECIP   = M_W'(((64'd1 << SH) + 64'd9) / 64'd10);
  localparam logic [R_W-1:0] LO_MASK = R_W'((64'd1 << FRACTION_BITS) - 64'd1);

  logic           p1_valid_r, p2_valid_r;
  logic           p1_rdy, p2_rdy;
  ted_pkg::tag_t  p1_tag_r;
  logic [U_W-1:0] p1_u_r, u_c, q, q10;
  logic           p1_lo_r, p1_exact_r;
  logic [P_W-1:0] p1_prod_r;
  logic [U_W:0]   euc;
  ted_pkg::dist_t dist_r, dist_nxt;
  logic           att_div;

  assign u_c = U_W'(up_root >> FRACTION_BITS);

  always_comb begin
    q        = U_W'(p1_prod_r >> SH);
    q10      = (q << 3) + (q << 1);
    att_div  = (q10 == p1_u_r) && !p1_lo_r && p1_exact_r;
    euc      = ((U_W + 1)'(p1_u_r) + (U_W + 1)'(1)) >> 1;
    unique case (p1_tag_r.metric) inside
      ted_pkg::METRIC_ATT:
        dist_nxt = att_div ? ted_pkg::DIST_W'(q) : ted_pkg::DIST_W'(q + U_W'(1));
      ted_pkg::METRIC_CEIL2D, ted_pkg::METRIC_CEIL3D:
        dist_nxt = ted_pkg::DIST_W'(p1_u_r + U_W'(p1_lo_r || !p1_exact_r));
      ted_pkg::METRIC_EUC2D, ted_pkg::METRIC_EUC3D:
        dist_nxt = ted_pkg::DIST_W'(euc);
      ted_pkg::METRIC_FLOOR2D, ted_pkg::METRIC_FLOOR3D:
        dist_nxt = ted_pkg::DIST_W'(p1_u_r);
      ted_pkg::METRIC_MAN2D, ted_pkg::METRIC_MAN3D,
      ted_pkg::METRIC_MAX2D, ted_pkg::METRIC_MAX3D:
        dist_nxt = p1_tag_r.alt;
      default:
        dist_nxt = '0;
    endcase
  end

  assign p2_rdy   = !p2_valid_r || dn_ready;
  assign p1_rdy   = !p1_valid_r || p2_rdy;
  assign up_ready = p1_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
    end else begin
      if (p1_rdy) p1_valid_r <= up_valid;
      if (p2_rdy) p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_rdy && up_valid) begin
      p1_tag_r   <= up_tag;
      p1_u_r     <= u_c;
      p1_lo_r    <= (up_root & LO_MASK) != '0;
      p1_exact_r <= (up_rem == '0);
      p1_prod_r  <= P_W'(u_c) * P_W'(RECIP);
    end
    if (p2_rdy && p1_valid_r) begin
      dist_r <= dist_nxt;
    end
  end

  assign dn_valid    = p2_valid_r;
  assign dn_distance = dist_r;

endmodule

FILE: rtl/ted_checker.sv
// ----------------------------------------------------------------------------
// TSP edge distance checker
// Port-level properties of the edge distance unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ted_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input ted_pkg::dist_t out_distance
);

  // stalled result transaction holds
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_distance), "result changed")

  // reset empties the pipeline
  `ASSERT_NXT_ALL(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")

  // a free or draining output lets every stage move, so input is taken
  `ASSERT_IMP(a_in_free, clk, rst_n, out_ready || !out_valid, in_ready, "input stalled")

endmodule

bind tsp_edge_distance_unit ted_checker u_ted_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance)
);

FILE: sim/ted_distance_checker.sv
// ----------------------------------------------------------------------------
// TSP edge distance checker
// Watches the point pair, distance and metric ports of the edge distance unit.
// It recomputes each edge weight with exact integer arithmetic, keeps the
// weights in acceptance order and compares them with the distances the unit
// delivers. Mismatch and pending counts go back to the testbench top.
// ----------------------------------------------------------------------------
module ted_distance_checker #(
  parameter int COORD_W = ted_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_W  = ted_pkg::FRACTION_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  ted_pkg::metric_t cfg_wdata,
  ted_point_if             pts,
  ted_dist_if              dst,
  output int               mismatches,
  output int               outstanding,
  output int               compared
);

  localparam longint unsigned ATT_SCALE = 10;

  ted_pkg::metric_t metric_q;
  ted_pkg::dist_t   weights_due[$];

  function automatic longint coord_value(ted_pkg::coord_t c);
    longint v;
    v = longint'(c);
    return (v <<< (64 - COORD_W)) >>> (64 - COORD_W);
  endfunction

  function automatic longint unsigned axis_gap(ted_pkg::coord_t a, ted_pkg::coord_t b);
    longint d;
    d = coord_value(a) - coord_value(b);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned probe;
    rem   = v;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  function automatic longint unsigned round_half_up(longint unsigned v);
    return (v + ((64'd1 << FRAC_W) >> 1)) >> FRAC_W;
  endfunction

  function automatic ted_pkg::dist_t edge_weight(ted_pkg::metric_t m,
                                                 ted_pkg::coord_t ax, ted_pkg::coord_t ay,
                                                 ted_pkg::coord_t az, ted_pkg::coord_t bx,
                                                 ted_pkg::coord_t by, ted_pkg::coord_t bz);
    longint unsigned dx, dy, dz, ssq, den, q, n, r, rx, ry, rz;
    logic use_z;
    dx = axis_gap(ax, bx);
    dy = axis_gap(ay, by);
    dz = axis_gap(az, bz);
    case (m)
      ted_pkg::METRIC_CEIL3D, ted_pkg::METRIC_EUC3D, ted_pkg::METRIC_FLOOR3D,
      ted_pkg::METRIC_MAN3D, ted_pkg::METRIC_MAX3D: use_z = 1'b1;
      default: use_z = 1'b0;
    endcase
    if (!use_z) dz = 0;
    ssq = dx * dx + dy * dy + dz * dz;
    r   = 0;
    case (m)
      ted_pkg::METRIC_ATT: begin
        den = ATT_SCALE << (2 * FRAC_W);
        q   = (ssq + den - 1) / den;
        n   = floor_root(q);
        if (n * n < q) n++;
        r = n;
      end
      ted_pkg::METRIC_CEIL2D, ted_pkg::METRIC_CEIL3D: begin
        n = floor_root(ssq) >> FRAC_W;
        if ((n << FRAC_W) * (n << FRAC_W) < ssq) n++;
        r = n;
      end
      ted_pkg::METRIC_EUC2D, ted_pkg::METRIC_EUC3D: begin
        n = floor_root(ssq << 2) >> FRAC_W;
        r = (n + 1) >> 1;
      end
      ted_pkg::METRIC_FLOOR2D, ted_pkg::METRIC_FLOOR3D: r = floor_root(ssq) >> FRAC_W;
      ted_pkg::METRIC_MAN2D, ted_pkg::METRIC_MAN3D: r = round_half_up(dx + dy + dz);
      ted_pkg::METRIC_MAX2D, ted_pkg::METRIC_MAX3D: begin
        rx = round_half_up(dx);
        ry = round_half_up(dy);
        rz = round_half_up(dz);
        r  = rx;
        if (ry > r) r = ry;
        if (rz > r) r = rz;
      end
      default: r = 0;
    endcase
    return ted_pkg::dist_t'(r);
  endfunction

  always @(posedge clk) begin
    ted_pkg::dist_t want;
    if (!rst_n) begin
      metric_q    = ted_pkg::METRIC_RESET;
      weights_due.delete();
      mismatches  = 0;
      compared    = 0;
    end else begin
      if (dst.valid === 1'b1 && dst.ready === 1'b1) begin
        if (weights_due.size() == 0) begin
          $display("%0t: distance %0d with no transaction pending", $time, dst.distance);
          mismatches++;
        end else begin
          want = weights_due.pop_front();
          compared++;
          if (dst.distance !== want) begin
            $display("%0t: distance mismatch, expected %0d, actual %0d",
                     $time, want, dst.distance);
            mismatches++;
          end
        end
      end
      if (pts.valid === 1'b1 && pts.ready === 1'b1)
        weights_due.push_back(edge_weight(metric_q, pts.ax, pts.ay, pts.az,
                                          pts.bx, pts.by, pts.bz));
      if (cfg_we === 1'b1) metric_q = cfg_wdata;
    end
    outstanding = weights_due.size();
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// TSP edge distance unit testbench
// Drives point pairs in random bursts under every metric code, with the
// distance side stalling in changing patterns. A short directed set covers
// coincident points, full-range differences, exact and half-unit distances
// and two unused codes; random pairs then mix full-range, near, half-unit
// and Pythagorean cases. The checker module does prediction and comparison.
// ----------------------------------------------------------------------------
module tb;

  localparam ted_pkg::metric_t METRIC_SPARE_LO = 4'd11;
  localparam ted_pkg::metric_t METRIC_SPARE_HI = 4'd15;
  localparam int               RANDOM_PAIRS    = 1800;
  localparam int               DRAIN_CYCLES    = 48;
  localparam int               CYCLE_LIMIT     = 300000;
  localparam ted_pkg::coord_t  COORD_MAX       = 24'sh7FFFFF;
  localparam ted_pkg::coord_t  COORD_MIN       = 24'sh800000;
  localparam int               LEG_X[8]        = '{3, 5, 8, 7, 20, 2, 1, 2};
  localparam int               LEG_Y[8]        = '{4, 12, 15, 24, 21, 3, 4, 6};
  localparam int               LEG_Z[8]        = '{0, 0, 0, 0, 0, 6, 8, 9};

  typedef struct packed {
    ted_pkg::coord_t ax, ay, az, bx, by, bz;
  } point_pair_t;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  ted_pkg::metric_t cfg_wdata;
  int               mismatches, outstanding, compared;
  int               sent;
  int               settings;
  int               cycles = 0;

  ted_point_if pts ();
  ted_dist_if  dst ();

  tsp_edge_distance_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pts),
    .out_ch    (dst)
  );

  ted_distance_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .pts         (pts),
    .dst         (dst),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .compared    (compared)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stall_mode_t mode;
    int          span;
    int          tick;
    dst.ready <= 1'b0;
    tick = 0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      span = $urandom_range(30, 300);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  dst.ready <= 1'b1;
          STALL_LIGHT: dst.ready <= ($urandom_range(0, 3) != 0);
          STALL_HEAVY: dst.ready <= ($urandom_range(0, 3) == 0);
          default:     dst.ready <= ((tick % 7) < 3);
        endcase
        tick++;
      end
    end
  end

  task automatic push_pair(input point_pair_t p);
    pts.valid <= 1'b1;
    pts.ax    <= p.ax;
    pts.ay    <= p.ay;
    pts.az    <= p.az;
    pts.bx    <= p.bx;
    pts.by    <= p.by;
    pts.bz    <= p.bz;
    do @(posedge clk); while (pts.ready !== 1'b1);
    sent++;
  endtask

  task automatic hold_off(input int n);
    pts.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // pause the sender until every pending distance is back
  task automatic settle();
    pts.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_metric(input ted_pkg::metric_t m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings++;
  endtask

  function automatic ted_pkg::coord_t signed_step(input int mag);
    return ($urandom_range(0, 1) != 0) ? ted_pkg::coord_t'(-mag) : ted_pkg::coord_t'(mag);
  endfunction

  function automatic ted_pkg::coord_t extreme_coord();
    case ($urandom_range(0, 6))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return ted_pkg::coord_t'(0);
      3:       return ted_pkg::coord_t'(-1);
      4:       return ted_pkg::coord_t'(1);
      5:       return COORD_MIN + ted_pkg::coord_t'(1);
      default: return COORD_MAX - ted_pkg::coord_t'(1);
    endcase
  endfunction

  function automatic point_pair_t offset_pair(input int dx, input int dy, input int dz);
    point_pair_t p;
    p.ax = ted_pkg::coord_t'($urandom);
    p.ay = ted_pkg::coord_t'($urandom);
    p.az = ted_pkg::coord_t'($urandom);
    p.bx = p.ax + signed_step(dx);
    p.by = p.ay + signed_step(dy);
    p.bz = p.az + signed_step(dz);
    return p;
  endfunction

  function automatic int half_or_whole();
    case ($urandom_range(0, 2))
      0:       return 8 * (2 * $urandom_range(0, 400) + 1);
      1:       return 16 * $urandom_range(0, 400);
      default: return 0;
    endcase
  endfunction

  function automatic point_pair_t random_pair();
    point_pair_t p;
    int          shape_roll;
    int          leg;
    int          scale;
    shape_roll = $urandom_range(0, 19);
    if (shape_roll < 4) begin
      p.ax = ted_pkg::coord_t'($urandom);
      p.ay = ted_pkg::coord_t'($urandom);
      p.az = ted_pkg::coord_t'($urandom);
      p.bx = ted_pkg::coord_t'($urandom);
      p.by = ted_pkg::coord_t'($urandom);
      p.bz = ted_pkg::coord_t'($urandom);
    end else if (shape_roll < 6) begin
      p.ax = extreme_coord();
      p.ay = extreme_coord();
      p.az = extreme_coord();
      p.bx = extreme_coord();
      p.by = extreme_coord();
      p.bz = extreme_coord();
    end else if (shape_roll < 11) begin
      p = offset_pair($urandom_range(0, 300), $urandom_range(0, 300), $urandom_range(0, 300));
    end else if (shape_roll < 15) begin
      p = offset_pair(half_or_whole(), half_or_whole(), half_or_whole());
    end else begin
      leg   = $urandom_range(0, 7);
      scale = 16 * $urandom_range(1, 2000);
      p = offset_pair(scale * LEG_X[leg] + $urandom_range(0, 2) - 1,
                      scale * LEG_Y[leg], scale * LEG_Z[leg]);
    end
    return p;
  endfunction

  task automatic run_random(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && count > 0) begin
        push_pair(random_pair());
        burst--;
        count--;
      end
      case ($urandom_range(0, 7))
        0, 1:    ;
        2:       hold_off($urandom_range(15, 40));
        default: hold_off($urandom_range(1, 6));
      endcase
    end
  endtask

  initial begin
    point_pair_t      wide;
    point_pair_t      halfway;
    point_pair_t      p;
    ted_pkg::metric_t plan[$];
    ted_pkg::metric_t m;
    ted_pkg::metric_t tmp;
    int               j;
    int               per_phase;

    sent      = 0;
    settings  = 0;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= ted_pkg::METRIC_RESET;
    pts.valid <= 1'b0;
    pts.ax    <= '0;
    pts.ay    <= '0;
    pts.az    <= '0;
    pts.bx    <= '0;
    pts.by    <= '0;
    pts.bz    <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset metric: coincident points and an exact 3-4-5 distance with z noise
    p = '{ax: 24'sd100, ay: -24'sd100, az: 24'sd7, bx: 24'sd100, by: -24'sd100, bz: 24'sd7};
    push_pair(p);
    p = '{ax: 24'sd0, ay: 24'sd0, az: 24'sd999, bx: 24'sd48, by: -24'sd64, bz: -24'sd5};
    push_pair(p);

    // full-range differences and half-unit axes under each metric and two spare codes
    wide    = '{ax: COORD_MAX, ay: COORD_MIN, az: COORD_MAX,
                bx: COORD_MIN, by: COORD_MAX, bz: COORD_MIN};
    halfway = '{ax: 24'sd24, ay: -24'sd3, az: -24'sd40,
                bx: 24'sd0, by: -24'sd3, bz: 24'sd0};
    for (int c = ted_pkg::METRIC_ATT; c <= ted_pkg::METRIC_MAX3D; c++)
      plan.push_back(ted_pkg::metric_t'(c));
    plan.push_back(METRIC_SPARE_LO);
    plan.push_back(METRIC_SPARE_HI);
    foreach (plan[i]) begin
      settle();
      set_metric(plan[i]);
      push_pair(wide);
      push_pair(halfway);
    end

    for (int i = plan.size() - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end
    per_phase = RANDOM_PAIRS / plan.size();
    foreach (plan[i]) begin
      m = plan[i];
      settle();
      set_metric(m);
      run_random(per_phase);
    end
    settle();

    $display("%0d point pairs sent, %0d distances compared over %0d metric writes",
             sent, compared, settings);
    $display("all eleven metrics plus two spare codes, directed edges and random bursts");
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ted_pkg.sv
rtl/ted_point_if.sv
rtl/ted_dist_if.sv
rtl/ted_cell.sv
rtl/ted_prep.sv
rtl/ted_post.sv
rtl/tsp_edge_distance_unit.sv
rtl/ted_checker.sv
sim/ted_distance_checker.sv
sim/tb.sv
